// ----- sv/qfs_pkg.sv -----
// Shared types, codes and saturating arithmetic for the quadcopter flight sequencer.
package qfs_pkg;

   typedef logic [2:0]         mode_type;
   typedef logic [3:0]         cmd_type;
   typedef logic [8:0]         base_type;
   typedef logic signed [9:0]  trim_type;
   typedef logic signed [15:0] offset_type;
   typedef logic [7:0]         drive_type;
   typedef logic [2:0]         csr_index_type;
   typedef logic [12:0]        csr_data_type;

   localparam mode_type MODE_LANDED  = 3'd0;
   localparam mode_type MODE_TAKEOFF = 3'd1;
   localparam mode_type MODE_STAB    = 3'd2;
   localparam mode_type MODE_FLY     = 3'd3;
   localparam mode_type MODE_LANDING = 3'd4;
   localparam mode_type MODE_TEST    = 3'd5;

   localparam cmd_type CMD_TICK      = 4'd0;
   localparam cmd_type CMD_LIFTOFF   = 4'd1;
   localparam cmd_type CMD_LAND      = 4'd2;
   localparam cmd_type CMD_SHUTDOWN  = 4'd3;
   localparam cmd_type CMD_TEST      = 4'd4;
   localparam cmd_type CMD_FLY       = 4'd5;
   localparam cmd_type CMD_STOP_UP   = 4'd6;
   localparam cmd_type CMD_STOP_DOWN = 4'd7;
   localparam cmd_type CMD_GO_F      = 4'd8;
   localparam cmd_type CMD_GO_B      = 4'd9;
   localparam cmd_type CMD_GO_L      = 4'd10;
   localparam cmd_type CMD_GO_R      = 4'd11;
   localparam cmd_type CMD_STOP_F    = 4'd12;
   localparam cmd_type CMD_STOP_B    = 4'd13;
   localparam cmd_type CMD_STOP_L    = 4'd14;
   localparam cmd_type CMD_STOP_R    = 4'd15;

   localparam csr_index_type CSR_TILT_THRESHOLD = 3'd0;
   localparam csr_index_type CSR_TRIM_STEP      = 3'd1;
   localparam csr_index_type CSR_CLIMB_STEP     = 3'd2;
   localparam csr_index_type CSR_MAX_BASE       = 3'd3;
   localparam csr_index_type CSR_TAKEOFF_BASE   = 3'd4;
   localparam csr_index_type CSR_HOVER_HEIGHT   = 3'd5;
   localparam csr_index_type CSR_LANDED_HEIGHT  = 3'd6;
   localparam csr_index_type CSR_MOVE_ANGLE     = 3'd7;

   localparam int MOTOR_NE = 0;
   localparam int MOTOR_NW = 1;
   localparam int MOTOR_SE = 2;
   localparam int MOTOR_SW = 3;

   localparam logic signed [16:0] WANTED_RISE_RATE  = 17'sd50;
   localparam logic [16:0]        STEADY_RATE_LIMIT = 17'd10;
   localparam logic signed [9:0]  MANUAL_STEP       = 10'sd10;
   localparam base_type           FLY_BASE          = 9'd100;
   localparam base_type           HOVER_RESET       = 9'd200;
   localparam trim_type           TEST_TRIM         = 10'sd50;

   function automatic trim_type trim_add(trim_type t, logic signed [9:0] d);
      logic signed [10:0] s;
      s = {t[9], t} + {d[9], d};
      if (s > 11'sd511) begin
         return 10'sh1FF;
      end else if (s < -11'sd512) begin
         return 10'sh200;
      end
      return s[9:0];
   endfunction

   function automatic base_type base_add(base_type b, logic signed [9:0] d);
      logic signed [10:0] s;
      s = {2'b00, b} + {d[9], d};
      if (s < 11'sd0) begin
         return 9'd0;
      end else if (s > 11'sd511) begin
         return 9'd511;
      end
      return s[8:0];
   endfunction

   function automatic offset_type offset_add(offset_type o, logic signed [13:0] d);
      logic signed [16:0] s;
      s = {o[15], o} + {{3{d[13]}}, d};
      if (s > 17'sd32767) begin
         return 16'sh7FFF;
      end else if (s < -17'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   function automatic drive_type drive_sat(trim_type t, base_type b);
      logic signed [10:0] s;
      s = {t[9], t} + {2'b00, b};
      if (s < 11'sd0) begin
         return 8'd0;
      end else if (s > 11'sd255) begin
         return 8'd255;
      end
      return s[7:0];
   endfunction

   function automatic logic [16:0] abs17(logic signed [16:0] e);
      logic signed [16:0] n;
      n = -e;
      return e[16] ? n : e;
   endfunction

endpackage

// ----- sv/quadcopter_flight_sequencer.sv -----
// Quadcopter flight sequencer: flight mode, speed ramps, trims and motor drives.
// Pipeline: an accepted transaction lands in the input register, and its result is
// then registered in the output register once that register is free or drained.
// Throughput: one transaction per cycle unless rsp_stall holds a result; flight state
// updates in the same cycle the result register loads; a following transaction sees it.
// Reset: synchronous, active high; landed, zero speed and trims, hover speed 200,
// configuration registers at their default values, both pipeline slots empty.
module quadcopter_flight_sequencer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  qfs_pkg::cmd_type         req_cmd,
   input  logic signed [15:0]       req_pitch,
   input  logic signed [15:0]       req_roll,
   input  logic [11:0]              req_distance,
   input  logic signed [15:0]       req_rise_rate,
   input  logic                     req_is_rising,
   input  logic                     req_is_falling,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output qfs_pkg::drive_type       rsp_ne_drive,
   output qfs_pkg::drive_type       rsp_nw_drive,
   output qfs_pkg::drive_type       rsp_se_drive,
   output qfs_pkg::drive_type       rsp_sw_drive,
   output qfs_pkg::mode_type        rsp_flight_mode,
   output logic                     rsp_takeoff_failed,
   input  logic                     csr_wen,
   input  qfs_pkg::csr_index_type   csr_index,
   input  qfs_pkg::csr_data_type    csr_data
);
   import qfs_pkg::*;

   logic [12:0] tilt_threshold_ff;
   logic [7:0]  trim_step_ff;
   logic [7:0]  climb_step_ff;
   logic [7:0]  max_base_ff;
   logic [7:0]  takeoff_base_ff;
   logic [11:0] hover_height_ff;
   logic [11:0] landed_height_ff;
   logic [12:0] move_angle_ff;

   logic               in_valid_ff, in_valid_in;
   cmd_type            cmd_ff;
   logic signed [15:0] pitch_ff, roll_ff, rate_ff;
   logic [11:0]        dist_ff;
   logic               rising_ff, falling_ff;

   logic       out_valid_ff, out_valid_in;
   drive_type  drive_ff [4];
   drive_type  drive_in [4];
   mode_type   out_mode_ff;
   logic       failed_ff, failed_in;

   mode_type   mode_ff, mode_in;
   base_type   base_ff, base_in;
   trim_type   trim_ff [4];
   trim_type   trim_in [4];
   base_type   hover_ff, hover_in;
   offset_type pitch_off_ff, pitch_off_in;
   offset_type roll_off_ff, roll_off_in;

   logic req_take, rsp_take, advance, process;

   logic signed [16:0] roll_err, pitch_err, rate_ext;
   logic               roll_big, pitch_big, steady;
   logic signed [9:0]  st_pos, st_neg, cs_pos, cs_neg;
   logic signed [13:0] mv_pos, mv_neg;
   logic [9:0]         climb_sum;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = out_valid_ff && !rsp_stall;
   assign process   = in_valid_ff && advance;

   assign roll_err  = {roll_ff[15], roll_ff} - {roll_off_ff[15], roll_off_ff};
   assign pitch_err = {pitch_ff[15], pitch_ff} - {pitch_off_ff[15], pitch_off_ff};
   assign roll_big  = abs17(roll_err) > {4'b0000, tilt_threshold_ff};
   assign pitch_big = abs17(pitch_err) > {4'b0000, tilt_threshold_ff};
   assign rate_ext  = {rate_ff[15], rate_ff};
   assign steady    = abs17(rate_ext) < STEADY_RATE_LIMIT;

   assign st_pos    = {2'b00, trim_step_ff};
   assign st_neg    = -st_pos;
   assign cs_pos    = {2'b00, climb_step_ff};
   assign cs_neg    = -cs_pos;
   assign mv_pos    = {1'b0, move_angle_ff};
   assign mv_neg    = -mv_pos;
   assign climb_sum = {1'b0, base_ff} + {2'b00, climb_step_ff};

   always_comb begin
      mode_in      = mode_ff;
      base_in      = base_ff;
      trim_in      = trim_ff;
      hover_in     = hover_ff;
      pitch_off_in = pitch_off_ff;
      roll_off_in  = roll_off_ff;
      failed_in    = 1'b0;
      if (cmd_ff == CMD_TICK) begin
         if (mode_ff != MODE_LANDED && mode_ff != MODE_TEST) begin
            if (roll_big) begin
               if (!roll_err[16]) begin
                  trim_in[MOTOR_NE] = trim_add(trim_in[MOTOR_NE], st_pos);
                  trim_in[MOTOR_NW] = trim_add(trim_in[MOTOR_NW], st_pos);
               end else begin
                  trim_in[MOTOR_NE] = trim_add(trim_in[MOTOR_NE], st_neg);
                  trim_in[MOTOR_NW] = trim_add(trim_in[MOTOR_NW], st_neg);
               end
            end
            if (pitch_big) begin
               if (!pitch_err[16]) begin
                  if (base_ff < hover_ff) begin
                     trim_in[MOTOR_NE] = trim_add(trim_in[MOTOR_NE], st_pos);
                     trim_in[MOTOR_SE] = trim_add(trim_in[MOTOR_SE], st_pos);
                  end
               end else begin
                  trim_in[MOTOR_NE] = trim_add(trim_in[MOTOR_NE], st_neg);
                  trim_in[MOTOR_SE] = trim_add(trim_in[MOTOR_SE], st_neg);
               end
            end
         end
         if (mode_in == MODE_TAKEOFF) begin
            if (rising_ff) begin
               if (rate_ext < WANTED_RISE_RATE) begin
                  base_in = base_add(base_in, cs_pos);
                  if (base_in > {1'b0, max_base_ff}) begin
                     base_in = {1'b0, max_base_ff};
                  end
               end
               if (dist_ff >= hover_height_ff) begin
                  mode_in = MODE_STAB;
               end
            end else if (climb_sum >= {2'b00, max_base_ff}) begin
               trim_in   = '{default: '0};
               base_in   = '0;
               mode_in   = MODE_LANDED;
               failed_in = 1'b1;
            end else begin
               base_in = base_add(base_in, cs_pos);
            end
         end
         if (mode_in == MODE_STAB) begin
            if (rising_ff) begin
               base_in = base_add(base_in, cs_neg);
            end else if (falling_ff) begin
               base_in = base_add(base_in, cs_pos);
            end else if (steady) begin
               mode_in  = MODE_FLY;
               hover_in = base_in;
            end
         end
         if (mode_in == MODE_LANDING) begin
            if (dist_ff < landed_height_ff) begin
               trim_in = '{default: '0};
               base_in = '0;
               mode_in = MODE_LANDED;
            end else if (base_in >= {1'b0, climb_step_ff}) begin
               base_in = base_in - {1'b0, climb_step_ff};
            end
         end
      end else begin
         case (cmd_ff)
            CMD_LIFTOFF: begin
               if (mode_ff == MODE_LANDED) begin
                  mode_in = MODE_TAKEOFF;
                  base_in = {1'b0, takeoff_base_ff};
               end
            end
            CMD_LAND: begin
               if (mode_ff != MODE_LANDED) begin
                  mode_in = MODE_LANDING;
               end
            end
            CMD_SHUTDOWN: begin
               trim_in = '{default: '0};
               base_in = '0;
               mode_in = MODE_LANDED;
            end
            CMD_TEST: begin
               mode_in = MODE_TEST;
            end
            CMD_FLY: begin
               mode_in = MODE_FLY;
               base_in = FLY_BASE;
            end
            CMD_STOP_UP: begin
               if (mode_ff == MODE_FLY) begin
                  base_in = base_add(base_ff, -MANUAL_STEP);
               end
            end
            CMD_STOP_DOWN: begin
               if (mode_ff == MODE_FLY) begin
                  base_in = base_add(base_ff, MANUAL_STEP);
               end
            end
            CMD_GO_F: begin
               if (mode_ff == MODE_FLY) begin
                  roll_off_in = offset_add(roll_off_ff, mv_pos);
               end else if (mode_ff == MODE_TEST) begin
                  trim_in[MOTOR_SW] = TEST_TRIM;
                  trim_in[MOTOR_SE] = TEST_TRIM;
               end
            end
            CMD_GO_B: begin
               if (mode_ff == MODE_FLY) begin
                  roll_off_in = offset_add(roll_off_ff, mv_neg);
               end else if (mode_ff == MODE_TEST) begin
                  trim_in[MOTOR_NW] = TEST_TRIM;
                  trim_in[MOTOR_NE] = TEST_TRIM;
               end
            end
            CMD_GO_L: begin
               if (mode_ff == MODE_FLY) begin
                  pitch_off_in = offset_add(pitch_off_ff, mv_neg);
               end else if (mode_ff == MODE_TEST) begin
                  trim_in[MOTOR_NE] = TEST_TRIM;
                  trim_in[MOTOR_SE] = TEST_TRIM;
               end
            end
            CMD_GO_R: begin
               if (mode_ff == MODE_FLY) begin
                  pitch_off_in = offset_add(pitch_off_ff, mv_pos);
               end else if (mode_ff == MODE_TEST) begin
                  trim_in[MOTOR_NW] = TEST_TRIM;
                  trim_in[MOTOR_SW] = TEST_TRIM;
               end
            end
            CMD_STOP_F, CMD_STOP_B, CMD_STOP_L, CMD_STOP_R: begin
               if (mode_ff == MODE_FLY) begin
                  case (cmd_ff)
                     CMD_STOP_F: roll_off_in  = offset_add(roll_off_ff, mv_neg);
                     CMD_STOP_B: roll_off_in  = offset_add(roll_off_ff, mv_pos);
                     CMD_STOP_L: pitch_off_in = offset_add(pitch_off_ff, mv_pos);
                     default:    pitch_off_in = offset_add(pitch_off_ff, mv_neg);
                  endcase
               end else if (mode_ff == MODE_TEST) begin
                  trim_in = '{default: '0};
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         drive_in[i] = (mode_in != MODE_LANDED) ? drive_sat(trim_in[i], base_in) : '0;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (process) begin
         out_valid_in = 1'b1;
      end else if (rsp_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_threshold_ff <= 13'd200;
         trim_step_ff      <= 8'd1;
         climb_step_ff     <= 8'd5;
         max_base_ff       <= 8'd250;
         takeoff_base_ff   <= 8'd100;
         hover_height_ff   <= 12'd1000;
         landed_height_ff  <= 12'd100;
         move_angle_ff     <= 13'd500;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_TILT_THRESHOLD: tilt_threshold_ff <= csr_data;
            CSR_TRIM_STEP:      trim_step_ff      <= csr_data[7:0];
            CSR_CLIMB_STEP:     climb_step_ff     <= csr_data[7:0];
            CSR_MAX_BASE:       max_base_ff       <= csr_data[7:0];
            CSR_TAKEOFF_BASE:   takeoff_base_ff   <= csr_data[7:0];
            CSR_HOVER_HEIGHT:   hover_height_ff   <= csr_data[11:0];
            CSR_LANDED_HEIGHT:  landed_height_ff  <= csr_data[11:0];
            CSR_MOVE_ANGLE:     move_angle_ff     <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_LANDED;
         base_ff      <= '0;
         trim_ff      <= '{default: '0};
         hover_ff     <= HOVER_RESET;
         pitch_off_ff <= '0;
         roll_off_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (process) begin
            mode_ff      <= mode_in;
            base_ff      <= base_in;
            trim_ff      <= trim_in;
            hover_ff     <= hover_in;
            pitch_off_ff <= pitch_off_in;
            roll_off_ff  <= roll_off_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= req_cmd;
         pitch_ff   <= req_pitch;
         roll_ff    <= req_roll;
         dist_ff    <= req_distance;
         rate_ff    <= req_rise_rate;
         rising_ff  <= req_is_rising;
         falling_ff <= req_is_falling;
      end
      if (process) begin
         drive_ff    <= drive_in;
         out_mode_ff <= mode_in;
         failed_ff   <= failed_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_ne_drive       = drive_ff[MOTOR_NE];
   assign rsp_nw_drive       = drive_ff[MOTOR_NW];
   assign rsp_se_drive       = drive_ff[MOTOR_SE];
   assign rsp_sw_drive       = drive_ff[MOTOR_SW];
   assign rsp_flight_mode    = out_mode_ff;
   assign rsp_takeoff_failed = failed_ff;

endmodule
